// ----- rtl/ssa_pkg.sv -----
// shared types, codes and reset constants of the slab slot allocator
package ssa_pkg;

  // default for the largest number of slots
  localparam int DEFAULT_MAX_SLOTS = 64;

  // register reset values
  localparam logic [31:0] RESET_BASE_ADDRESS = 32'd4096;
  localparam logic [15:0] RESET_SLOT_SIZE    = 16'd64;
  localparam int          RESET_SLOT_COUNT   = 64;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_SLOT_SIZE    = 2'd1;
  localparam logic [1:0] CFG_SLOT_COUNT   = 2'd2;

  // request kinds
  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_NOT_IN_SLAB  = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_CHECK
  } state_t;

  // request word
  typedef struct packed {
    action_t     action;
    logic [31:0] address;
  } req_t;

  // result word
  typedef struct packed {
    logic [31:0] slot_address;
    status_t     status;
    logic [6:0]  free_count;
  } rsp_t;

endpackage

// ----- rtl/slab_slot_allocator.sv -----
// slab slot allocator: free-bit scan and offset division on one shared add/subtract unit
// allocate scans upward from slot 0 for the lowest free slot and reports full if none is left;
// release divides the offset by the slot size; null and out-of-slab addresses report not in slab
// one word in work at a time, the next accepted the cycle after the result loads, and a word
// in work is also held back while the result side stalls
// reset: configuration registers take their defaults and every free bit is set at once, no clearing pass
module slab_slot_allocator #(
  parameter int MAX_SLOTS = ssa_pkg::DEFAULT_MAX_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          req_valid,
  output logic          req_stall,
  input  ssa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ssa_pkg::rsp_t rsp
);

  // slots reachable through the 7-bit slot count
  localparam int ENTRIES   = (MAX_SLOTS < 127) ? MAX_SLOTS : 127;
  localparam int CW        = $clog2(ENTRIES + 1);
  localparam int IW        = $clog2(ENTRIES);
  localparam int RESET_EFF =
    (MAX_SLOTS < ssa_pkg::RESET_SLOT_COUNT) ? MAX_SLOTS : ssa_pkg::RESET_SLOT_COUNT;

  // configuration
  logic [31:0] base_address;
  logic [15:0] slot_size;
  logic [CW-1:0] eff_count;

  // slab state
  logic [ENTRIES-1:0] free_bits, free_bits_next;
  logic [CW-1:0]      free_slots, free_slots_next;

  // sequencer and work registers
  ssa_pkg::state_t state, state_next;
  logic [31:0]     work, work_next;
  logic [CW-1:0]   count, count_next;
  logic            null_addr, null_addr_next;

  // result load
  logic             load_out;
  logic             out_free;
  logic [31:0]      res_addr;
  ssa_pkg::status_t res_status;

  // shared add/subtract unit
  logic [31:0] unit_a, unit_b, unit_sum;
  logic        unit_sub, unit_carry;

  assign {unit_carry, unit_sum} = {1'b0, unit_a} + {1'b0, unit_sub ? ~unit_b : unit_b}
                                  + {32'd0, unit_sub};

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ssa_pkg::S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, unit operands and result
  always_comb begin
    state_next      = state;
    work_next       = work;
    count_next      = count;
    null_addr_next  = null_addr;
    free_bits_next  = free_bits;
    free_slots_next = free_slots;
    load_out        = 1'b0;
    res_addr        = 32'd0;
    res_status      = ssa_pkg::ST_OK;
    unit_a          = work;
    unit_b          = {16'd0, slot_size};
    unit_sub        = 1'b0;
    unique case (state)
      ssa_pkg::S_IDLE: begin
        if (req_valid) begin
          count_next = '0;
          if (req.action == ssa_pkg::ACT_RELEASE) begin
            // offset of the address from the slab base
            unit_a         = req.address;
            unit_b         = base_address;
            unit_sub       = 1'b1;
            work_next      = unit_sum;
            null_addr_next = (req.address == 32'd0);
            state_next     = ssa_pkg::S_DIV;
          end else begin
            work_next  = base_address;
            state_next = ssa_pkg::S_SCAN;
          end
        end
      end
      ssa_pkg::S_SCAN: begin
        // one free bit a cycle, slot address accumulated alongside
        if (free_slots == '0 || count == eff_count) begin
          if (out_free) begin
            load_out   = 1'b1;
            res_status = ssa_pkg::ST_FULL;
            state_next = ssa_pkg::S_IDLE;
          end
        end else if (free_bits[count[IW-1:0]]) begin
          if (out_free) begin
            load_out                         = 1'b1;
            res_addr                         = work;
            free_bits_next[count[IW-1:0]]    = 1'b0;
            free_slots_next                  = free_slots - CW'(1);
            state_next                       = ssa_pkg::S_IDLE;
          end
        end else begin
          work_next  = unit_sum;
          count_next = count + CW'(1);
        end
      end
      ssa_pkg::S_DIV: begin
        // repeated subtraction of the slot size, bounded by the slot count
        if (null_addr || count == eff_count) begin
          if (out_free) begin
            load_out   = 1'b1;
            res_status = ssa_pkg::ST_NOT_IN_SLAB;
            state_next = ssa_pkg::S_IDLE;
          end
        end else begin
          unit_sub = 1'b1;
          if (!unit_carry) begin
            state_next = ssa_pkg::S_CHECK;
          end else begin
            work_next  = unit_sum;
            count_next = count + CW'(1);
          end
        end
      end
      ssa_pkg::S_CHECK: begin
        // free the slot unless it is free already
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ssa_pkg::S_IDLE;
          if (free_bits[count[IW-1:0]]) begin
            res_status = ssa_pkg::ST_ALREADY_FREE;
          end else begin
            free_bits_next[count[IW-1:0]] = 1'b1;
            free_slots_next               = free_slots + CW'(1);
          end
        end
      end
      default: begin
        state_next = ssa_pkg::S_IDLE;
      end
    endcase
  end

  // configuration and slab state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= ssa_pkg::RESET_BASE_ADDRESS;
      slot_size    <= ssa_pkg::RESET_SLOT_SIZE;
      eff_count    <= CW'(RESET_EFF);
      free_bits    <= '1;
      free_slots   <= CW'(RESET_EFF);
    end else if (cfg_write && cfg_index == ssa_pkg::CFG_SLOT_COUNT) begin
      // new count saturated to the slot maximum, slab reinitialised
      if ({25'd0, cfg_data[6:0]} > 32'(MAX_SLOTS)) begin
        eff_count  <= CW'(ENTRIES);
        free_slots <= CW'(ENTRIES);
      end else begin
        eff_count  <= CW'(cfg_data[6:0]);
        free_slots <= CW'(cfg_data[6:0]);
      end
      free_bits <= '1;
    end else begin
      free_bits  <= free_bits_next;
      free_slots <= free_slots_next;
      if (cfg_write) begin
        unique case (cfg_index)
          ssa_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data;
          ssa_pkg::CFG_SLOT_SIZE:    slot_size    <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    work      <= work_next;
    count     <= count_next;
    null_addr <= null_addr_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.slot_address <= res_addr;
      rsp.status       <= res_status;
      rsp.free_count   <= 7'(free_slots_next);
    end
  end

`ifndef SYNTHESIS
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> !load_out)
    else $error("result register loaded while a word waits");

  // full is only reported by the scan
  a_full_from_scan: assert property (@(posedge clk) disable iff (rst)
    load_out && res_status == ssa_pkg::ST_FULL |-> state == ssa_pkg::S_SCAN)
    else $error("full status outside the scan");

  // a granted slot is marked used
  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    load_out && state == ssa_pkg::S_SCAN && res_status == ssa_pkg::ST_OK && !cfg_write
    |=> !free_bits[$past(count[IW-1:0])])
    else $error("allocated slot still marked free");

  // a good release adds one free slot
  a_release_counts: assert property (@(posedge clk) disable iff (rst)
    load_out && state == ssa_pkg::S_CHECK && res_status == ssa_pkg::ST_OK && !cfg_write
    |=> free_slots == $past(free_slots) + CW'(1))
    else $error("free count not raised on release");
`endif

endmodule
